// ===== src/tpq_pkg.sv =====
// Shared types and constants for the task priority queue.
// No dependencies; used by tpq_cell and task_priority_queue.
package tpq_pkg;

    localparam int TYPE_W   = 2;
    localparam int TASK_W   = 16;
    localparam int USER_W   = 16;
    localparam int PRIO_W   = 30;
    localparam int STATUS_W = 2;

    localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_EDIT   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_EXEC   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [TASK_W-1:0] task_id;
        logic [USER_W-1:0] user_id;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [USER_W-1:0]   top_user;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] task_id;
        logic [USER_W-1:0] user_id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [PRIO_W-1:0] cmp_prio;
        logic [TASK_W-1:0] cmp_task;
        logic [USER_W-1:0] ins_user;
        logic [TASK_W-1:0] find_task;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_REMOVE,
        FSM_INSERT,
        FSM_RESPOND
    } fsm_state_t;

endpackage

// ===== src/task_priority_queue.sv =====
// Each request is matched on its beat and its status is registered, then
// written to the result register once the output is free; a replacing add
// or an edit removes, then re-inserts, one cell-chain shift per table change.
// A new request is taken only in idle, after the last result is written.
// Reset: synchronous, clears every slot's valid bit at once; no clearing pass.
// Top level: sorted chain of tpq_cell slots and its sequencer; uses tpq_pkg.
module task_priority_queue #(
    parameter int TASK_SLOTS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tpq_pkg::req_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tpq_pkg::rsp_t   m_data
);

    tpq_pkg::entry_t    entries [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] gts;
    logic [TASK_SLOTS-1:0] hit_vec;
    tpq_pkg::cell_ctl_t ctl;

    tpq_pkg::fsm_state_t state_reg;
    tpq_pkg::fsm_state_t state_next;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    tpq_pkg::rsp_t                m_data_reg;
    logic [tpq_pkg::PRIO_W-1:0]   ins_prio_reg;
    logic [tpq_pkg::TASK_W-1:0]   ins_task_reg;
    logic [tpq_pkg::USER_W-1:0]   ins_user_reg;
    logic [tpq_pkg::PRIO_W-1:0]   rm_prio_reg;
    logic [tpq_pkg::TASK_W-1:0]   rm_task_reg;
    logic                         ins_after_reg;
    logic [tpq_pkg::STATUS_W-1:0] status_reg;
    logic [tpq_pkg::USER_W-1:0]   top_reg;

    logic                         in_beat;
    logic                         out_free;
    logic                         out_wr;

    logic                         hit_any;
    logic [tpq_pkg::PRIO_W-1:0]   hit_prio;
    logic [tpq_pkg::TASK_W-1:0]   hit_task;
    logic [tpq_pkg::USER_W-1:0]   hit_user;
    logic                         find;
    logic [tpq_pkg::PRIO_W-1:0]   find_prio;
    logic [tpq_pkg::TASK_W-1:0]   find_task;
    logic [tpq_pkg::USER_W-1:0]   find_user;

    tpq_pkg::fsm_state_t          dec_state;
    logic                         dec_ins_after;
    logic [tpq_pkg::USER_W-1:0]   dec_ins_user;
    logic [tpq_pkg::STATUS_W-1:0] dec_status;
    logic [tpq_pkg::USER_W-1:0]   dec_top;

    genvar g;
    generate
        for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
            tpq_pkg::entry_t left_e;
            tpq_pkg::entry_t right_e;
            logic            left_g;
            if (g == 0) begin : g_first
                assign left_e = '0;
                assign left_g = 1'b1;
            end else begin : g_mid_l
                assign left_e = entries[g-1];
                assign left_g = gts[g-1];
            end
            if (g == TASK_SLOTS - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_mid_r
                assign right_e = entries[g+1];
            end
            tpq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .entry_o     (entries[g]),
                .gt_o        (gts[g]),
                .match_o     (hit_vec[g])
            );
        end
    endgenerate

    assign out_free = !m_valid_reg || m_ready;
    assign in_beat  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        hit_any  = 1'b0;
        hit_prio = '0;
        hit_task = '0;
        hit_user = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            hit_any  = hit_any | hit_vec[i];
            hit_prio = hit_prio | (entries[i].prio & {tpq_pkg::PRIO_W{hit_vec[i]}});
            hit_task = hit_task | (entries[i].task_id & {tpq_pkg::TASK_W{hit_vec[i]}});
            hit_user = hit_user | (entries[i].user_id & {tpq_pkg::USER_W{hit_vec[i]}});
        end
    end

    always_comb begin
        if (s_data.req_type == tpq_pkg::REQ_EXEC) begin
            find      = entries[0].valid;
            find_prio = entries[0].prio;
            find_task = entries[0].task_id;
            find_user = entries[0].user_id;
        end else begin
            find      = hit_any;
            find_prio = hit_prio;
            find_task = hit_task;
            find_user = hit_user;
        end
    end

    always_comb begin
        dec_state     = tpq_pkg::FSM_RESPOND;
        dec_ins_after = 1'b0;
        dec_ins_user  = s_data.user_id;
        dec_status    = tpq_pkg::STAT_OK;
        dec_top       = '0;
        case (s_data.req_type)
            tpq_pkg::REQ_ADD: begin
                if (find) begin
                    dec_state     = tpq_pkg::FSM_REMOVE;
                    dec_ins_after = 1'b1;
                end else if (entries[TASK_SLOTS-1].valid) begin
                    dec_status = tpq_pkg::STAT_FULL;
                end else begin
                    dec_state = tpq_pkg::FSM_INSERT;
                end
            end
            tpq_pkg::REQ_EDIT: begin
                dec_ins_user = find_user;
                if (find) begin
                    dec_state     = tpq_pkg::FSM_REMOVE;
                    dec_ins_after = 1'b1;
                end else begin
                    dec_status = tpq_pkg::STAT_NOT_FOUND;
                end
            end
            tpq_pkg::REQ_REMOVE: begin
                if (find) begin
                    dec_state = tpq_pkg::FSM_REMOVE;
                end else begin
                    dec_status = tpq_pkg::STAT_NOT_FOUND;
                end
            end
            default: begin
                if (find) begin
                    dec_state = tpq_pkg::FSM_REMOVE;
                    dec_top   = find_user;
                end else begin
                    dec_status = tpq_pkg::STAT_EMPTY;
                end
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tpq_pkg::FSM_IDLE: begin
                if (in_beat) begin
                    state_next = dec_state;
                end
            end
            tpq_pkg::FSM_REMOVE: begin
                if (ins_after_reg) begin
                    state_next = tpq_pkg::FSM_INSERT;
                end else if (out_free) begin
                    state_next = tpq_pkg::FSM_IDLE;
                end
            end
            tpq_pkg::FSM_INSERT, tpq_pkg::FSM_RESPOND: begin
                if (out_free) begin
                    state_next = tpq_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = tpq_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        out_wr        = 1'b0;
        ctl.op        = tpq_pkg::CELL_HOLD;
        ctl.cmp_prio  = ins_prio_reg;
        ctl.cmp_task  = ins_task_reg;
        ctl.ins_user  = ins_user_reg;
        ctl.find_task = s_data.task_id;
        case (state_reg)
            tpq_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
            end
            tpq_pkg::FSM_REMOVE: begin
                ctl.cmp_prio = rm_prio_reg;
                ctl.cmp_task = rm_task_reg;
                if (ins_after_reg) begin
                    ctl.op = tpq_pkg::CELL_REMOVE;
                end else if (out_free) begin
                    ctl.op = tpq_pkg::CELL_REMOVE;
                    out_wr = 1'b1;
                end
            end
            tpq_pkg::FSM_INSERT: begin
                if (out_free) begin
                    ctl.op = tpq_pkg::CELL_INSERT;
                    out_wr = 1'b1;
                end
            end
            tpq_pkg::FSM_RESPOND: begin
                out_wr = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_wr) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tpq_pkg::FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            ins_prio_reg  <= s_data.priority_req;
            ins_task_reg  <= s_data.task_id;
            ins_user_reg  <= dec_ins_user;
            rm_prio_reg   <= find_prio;
            rm_task_reg   <= find_task;
            ins_after_reg <= dec_ins_after;
            status_reg    <= dec_status;
            top_reg       <= dec_top;
        end
        if (out_wr) begin
            m_data_reg.status   <= status_reg;
            m_data_reg.top_user <= top_reg;
        end
    end

endmodule

// ===== src/tpq_cell.sv =====
// One slot of the sorted task chain: holds an entry, compares it against the
// broadcast key and takes data from its left or right neighbour or the broadcast insert entry. Uses tpq_pkg.
module tpq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  tpq_pkg::cell_ctl_t ctl,
    input  tpq_pkg::entry_t    left_entry,
    input  logic               left_gt,
    input  tpq_pkg::entry_t    right_entry,
    output tpq_pkg::entry_t    entry_o,
    output logic               gt_o,
    output logic               match_o
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [tpq_pkg::TASK_W-1:0] task_reg;
    logic [tpq_pkg::TASK_W-1:0] task_next;
    logic [tpq_pkg::USER_W-1:0] user_reg;
    logic [tpq_pkg::USER_W-1:0] user_next;
    logic [tpq_pkg::PRIO_W-1:0] prio_reg;
    logic [tpq_pkg::PRIO_W-1:0] prio_next;

    assign entry_o.valid   = valid_reg;
    assign entry_o.task_id = task_reg;
    assign entry_o.user_id = user_reg;
    assign entry_o.prio    = prio_reg;

    assign gt_o    = valid_reg && ({prio_reg, task_reg} > {ctl.cmp_prio, ctl.cmp_task});
    assign match_o = valid_reg && (task_reg == ctl.find_task);

    always_comb begin
        valid_next = valid_reg;
        task_next  = task_reg;
        user_next  = user_reg;
        prio_next  = prio_reg;
        case (ctl.op)
            tpq_pkg::CELL_REMOVE: begin
                if (!gt_o) begin
                    valid_next = right_entry.valid;
                    task_next  = right_entry.task_id;
                    user_next  = right_entry.user_id;
                    prio_next  = right_entry.prio;
                end
            end
            tpq_pkg::CELL_INSERT: begin
                if (!gt_o) begin
                    if (left_gt) begin
                        valid_next = 1'b1;
                        task_next  = ctl.cmp_task;
                        user_next  = ctl.ins_user;
                        prio_next  = ctl.cmp_prio;
                    end else begin
                        valid_next = left_entry.valid;
                        task_next  = left_entry.task_id;
                        user_next  = left_entry.user_id;
                        prio_next  = left_entry.prio;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        task_reg <= task_next;
        user_reg <= user_next;
        prio_reg <= prio_next;
    end

endmodule

// ===== verif/task_priority_queue_tb.sv =====
// Self-checking testbench for task_priority_queue: directed and random requests
// are checked against a table-based prediction of every response beat.
// Depends on tpq_pkg and task_priority_queue from src.

class tpq_scoreboard;
    bit                         slot_live[];
    logic [tpq_pkg::TASK_W-1:0] slot_task[];
    logic [tpq_pkg::USER_W-1:0] slot_user[];
    logic [tpq_pkg::PRIO_W-1:0] slot_prio[];
    tpq_pkg::rsp_t              expected_rsp[$];
    int                         errors;

    function new(int slots);
        slot_live = new[slots];
        slot_task = new[slots];
        slot_user = new[slots];
        slot_prio = new[slots];
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        errors = 0;
    endfunction

    function void note_request(tpq_pkg::req_t req);
        tpq_pkg::rsp_t rsp;
        int            hit;
        int            spot;
        rsp.status   = tpq_pkg::STAT_OK;
        rsp.top_user = '0;
        hit  = -1;
        spot = -1;
        foreach (slot_live[i]) begin
            if (hit < 0 && slot_live[i] && slot_task[i] == req.task_id) hit = i;
        end
        case (req.req_type)
            tpq_pkg::REQ_ADD: begin
                spot = hit;
                if (spot < 0) begin
                    foreach (slot_live[i]) begin
                        if (spot < 0 && !slot_live[i]) spot = i;
                    end
                end
                if (spot < 0) begin
                    rsp.status = tpq_pkg::STAT_FULL;
                end else begin
                    slot_live[spot] = 1'b1;
                    slot_task[spot] = req.task_id;
                    slot_user[spot] = req.user_id;
                    slot_prio[spot] = req.priority_req;
                end
            end
            tpq_pkg::REQ_EDIT: begin
                if (hit < 0) rsp.status = tpq_pkg::STAT_NOT_FOUND;
                else slot_prio[hit] = req.priority_req;
            end
            tpq_pkg::REQ_REMOVE: begin
                if (hit < 0) rsp.status = tpq_pkg::STAT_NOT_FOUND;
                else slot_live[hit] = 1'b0;
            end
            tpq_pkg::REQ_EXEC: begin
                foreach (slot_live[i]) begin
                    if (slot_live[i] && (spot < 0 || slot_prio[i] > slot_prio[spot] ||
                        (slot_prio[i] == slot_prio[spot] && slot_task[i] > slot_task[spot])))
                        spot = i;
                end
                if (spot < 0) begin
                    rsp.status = tpq_pkg::STAT_EMPTY;
                end else begin
                    rsp.top_user    = slot_user[spot];
                    slot_live[spot] = 1'b0;
                end
            end
        endcase
        expected_rsp.push_back(rsp);
    endfunction

    function void check_response(tpq_pkg::rsp_t got);
        tpq_pkg::rsp_t want;
        if (expected_rsp.size() == 0) begin
            $error("response beat with none expected: status %0d top_user 0x%0h",
                   got.status, got.top_user);
            errors++;
            return;
        end
        want = expected_rsp.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.top_user !== want.top_user) begin
            $error("top_user: expected 0x%0h, got 0x%0h", want.top_user, got.top_user);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_rsp.size();
    endfunction
endclass

module task_priority_queue_tb;
    import tpq_pkg::*;

    localparam int                SLOTS       = 64;
    localparam int                CYCLE_LIMIT = 200000;
    localparam int                ID_POOL     = 80;
    localparam logic [PRIO_W-1:0] PRIO_MAX    = '1;
    localparam logic [USER_W-1:0] USER_MAX    = '1;
    localparam logic [TASK_W-1:0] TASK_MAX    = '1;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    tpq_scoreboard sb = new(SLOTS);
    bit            steady    = 1'b0;
    int            recv_hold = 0;
    int            cycles    = 0;

    always #4 aclk = ~aclk;

    task_priority_queue #(
        .TASK_SLOTS(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic req_t make_req(logic [TYPE_W-1:0] kind, logic [TASK_W-1:0] id,
                                      logic [USER_W-1:0] user, logic [PRIO_W-1:0] prio);
        req_t req;
        req.req_type     = kind;
        req.task_id      = id;
        req.user_id      = user;
        req.priority_req = prio;
        return req;
    endfunction

    function automatic req_t random_request(int add_w, int edit_w, int remove_w);
        req_t req;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < add_w) req.req_type = REQ_ADD;
        else if (pick < add_w + edit_w) req.req_type = REQ_EDIT;
        else if (pick < add_w + edit_w + remove_w) req.req_type = REQ_REMOVE;
        else req.req_type = REQ_EXEC;
        // mostly a small id pool so that lookups hit; now and then any id
        if ($urandom_range(0, 9) == 0) req.task_id = TASK_W'($urandom);
        else req.task_id = TASK_W'($urandom_range(0, ID_POOL - 1));
        req.user_id = USER_W'($urandom);
        // narrow priorities force ties on the task id
        if ($urandom_range(0, 1) == 0) req.priority_req = PRIO_W'($urandom_range(0, 3));
        else req.priority_req = PRIO_W'($urandom);
        return req;
    endfunction

    task automatic send_request(req_t req);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) repeat (gap) @(negedge aclk);
        s_data  = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    initial begin : drain_results
        int stall;
        wait (aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 11);
            if (recv_hold > 0) begin
                stall     = recv_hold;
                recv_hold = 0;
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_response(m_data);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_request(make_req(REQ_EXEC, 16'd0, 16'd0, '0));
        send_request(make_req(REQ_EDIT, 16'd0, USER_MAX, PRIO_MAX));
        send_request(make_req(REQ_REMOVE, TASK_MAX, 16'd0, '0));
        send_request(make_req(REQ_ADD, 16'd0, USER_MAX, '0));
        send_request(make_req(REQ_ADD, TASK_MAX, 16'd0, PRIO_MAX));
        send_request(make_req(REQ_ADD, 16'd100, 16'h1234, PRIO_MAX));
        send_request(make_req(REQ_ADD, 16'd100, 16'habcd, 30'd5));
        send_request(make_req(REQ_EDIT, 16'd0, 16'd0, PRIO_MAX));
        send_request(make_req(REQ_EXEC, TASK_MAX, USER_MAX, PRIO_MAX));
        send_request(make_req(REQ_EXEC, 16'd0, 16'd0, '0));
        send_request(make_req(REQ_ADD, 16'h5555, 16'haaaa, 30'h2aaaaaaa));
        send_request(make_req(REQ_ADD, 16'haaaa, 16'h5555, 30'h15555555));
        send_request(make_req(REQ_EDIT, 16'h5555, 16'd0, 30'd1));
        send_request(make_req(REQ_REMOVE, 16'd100, 16'd0, '0));
        send_request(make_req(REQ_REMOVE, 16'd100, 16'd0, '0));
        send_request(make_req(REQ_EXEC, 16'd0, 16'd0, '0));
        send_request(make_req(REQ_EXEC, 16'd0, 16'd0, '0));
        send_request(make_req(REQ_EXEC, 16'd0, 16'd0, '0));

        // alternate filling the table past full and draining it past empty
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 2) recv_hold = 300;
            if (phase == 5) begin
                while (sb.outstanding() != 0) @(negedge aclk);
            end
            steady = (phase == 6);
            if (phase % 2 == 0) begin
                for (n = 0; n < 200; n++) send_request(random_request(85, 5, 5));
            end else begin
                for (n = 0; n < 125; n++) send_request(random_request(15, 15, 20));
            end
        end
        steady = 1'b0;

        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (sb.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
